[hw/rtl/msd_pkg.sv]
`default_nettype none

package msd_pkg;

    localparam int MAX_ELEMENTS_DEF = 64;

    typedef struct packed {
        logic [63:0] value_bits;
        logic        last_in;
    } msd_in_t;

    typedef struct packed {
        logic [63:0] sorted_bits;
        logic        last_out;
        logic        overflow;
    } msd_out_t;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PLAN,
        S_MRD,
        S_MWR,
        S_CRD,
        S_CWR,
        S_ORD,
        S_OSHOW
    } msd_state_t;

endpackage

`default_nettype wire

[hw/rtl/msd_fp_less.sv]
`default_nettype none

module msd_fp_less (
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        less
);
    localparam logic [62:0] INF_MAG = 63'h7FF0000000000000;

    logic [62:0] ma;
    logic [62:0] mb;
    logic        na;
    logic        nb;

    assign ma = a[62:0];
    assign mb = b[62:0];
    assign na = a[63];
    assign nb = b[63];

    // NaN on either side, or two zeros of any sign: not less
    always_comb
    begin
        if (ma > INF_MAG || mb > INF_MAG)
            less = 1'b0;
        else if (ma == '0 && mb == '0)
            less = 1'b0;
        else if (na != nb)
            less = na;
        else if (!na)
            less = ma < mb;
        else
            less = ma > mb;
    end

endmodule

`default_nettype wire

[hw/rtl/merge_sort_doubles.sv]
`default_nettype none

// Merge sorter for IEEE-754 double bit patterns. Words arrive on the src
// channel, one element each; the word with last_in set closes the set (at
// least one word, at most MAX_ELEMENTS kept; extra words are dropped and
// every result of that run carries overflow). While loading, one word is
// taken per cycle. The block then sorts top-down (left half floor(n/2),
// right half the rest, IEEE less-than, right element taken on a failed
// compare) with one shared compare unit and a small split stack, and
// stalls src until the last result leaves. Each merge level reads the
// two run heads, writes the chosen element to scratch, then copies the
// merged run back through the single write port of the element store. A
// run on the stack is split on its first visit and merged on its second;
// a single element is popped, and the sort ends when the stack is empty.
// Results then leave one at a time, each held until dst takes it, the
// final one flagged with last_out.
module merge_sort_doubles #(
    parameter int MAX_ELEMENTS = msd_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             src_valid,
    output logic                  src_stall,
    input  wire msd_pkg::msd_in_t src_word,
    output logic                  dst_valid,
    input  wire logic             dst_stall,
    output msd_pkg::msd_out_t     dst_word
);
    import msd_pkg::*;

    localparam int AW  = $clog2(MAX_ELEMENTS);
    localparam int CW  = $clog2(MAX_ELEMENTS + 1);
    localparam int SD  = 2 * AW + 2;
    localparam int SAW = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ELEMENTS);

    msd_state_t state_reg, state_next;

    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           ovf_reg, ovf_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [CW-1:0]  li_reg, li_next;
    logic [CW-1:0]  le_reg, le_next;
    logic [CW-1:0]  ri_reg, ri_next;
    logic [CW-1:0]  re_reg, re_next;
    logic [CW-1:0]  k_reg, k_next;
    logic [CW-1:0]  mlo_reg, mlo_next;
    logic [CW-1:0]  idx_reg, idx_next;

    logic [63:0] store_mem [MAX_ELEMENTS];
    logic [63:0] scratch_mem [MAX_ELEMENTS];
    logic [63:0] da_reg;
    logic [63:0] db_reg;
    logic [63:0] sc_reg;

    logic [CW-1:0] stk_lo [SD];
    logic [CW-1:0] stk_n [SD];
    logic          stk_exp [SD];

    logic           src_take;
    logic           dst_take;
    logic [CW-1:0]  cnt_inc;
    logic [SPW-1:0] sp_dec;
    logic [SPW-1:0] sp_inc;
    logic [SAW-1:0] top_idx;
    logic [SAW-1:0] push0_idx;
    logic [SAW-1:0] push1_idx;
    logic [CW-1:0]  tlo;
    logic [CW-1:0]  tn;
    logic           texp;
    logic [CW-1:0]  th;
    logic           stk_root;
    logic           stk_split;
    logic           less;
    logic           take_left;
    logic [63:0]    chosen;
    logic           merge_done;
    logic           copy_done;
    logic           is_last;

    logic          st_we;
    logic [AW-1:0] st_waddr;
    logic [63:0]   st_wdata;
    logic          rd_en;
    logic [AW-1:0] ra;
    logic [AW-1:0] rb;
    logic          sc_we;
    logic          sc_re;

    msd_fp_less u_less (
        .a    (da_reg),
        .b    (db_reg),
        .less (less)
    );

    assign src_take = src_valid && !src_stall;
    assign dst_take = dst_valid && !dst_stall;
    assign cnt_inc  = (cnt_reg < CNT_MAX) ? cnt_reg + CW'(1) : cnt_reg;

    // stack top and the two push slots above it
    assign sp_dec    = sp_reg - SPW'(1);
    assign sp_inc    = sp_reg + SPW'(1);
    assign top_idx   = sp_dec[SAW-1:0];
    assign push0_idx = sp_reg[SAW-1:0];
    assign push1_idx = sp_inc[SAW-1:0];
    assign tlo       = stk_lo[top_idx];
    assign tn        = stk_n[top_idx];
    assign texp      = stk_exp[top_idx];
    assign th        = tn >> 1;

    // right run wins ties and NaN compares; an exhausted side yields
    assign take_left  = (li_reg < le_reg) && ((ri_reg == re_reg) || less);
    assign chosen     = take_left ? da_reg : db_reg;
    assign merge_done = (k_reg + CW'(1)) == re_reg;
    assign copy_done  = merge_done;
    assign is_last    = (idx_reg + CW'(1)) == cnt_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (src_take && src_word.last_in)
                    state_next = S_PLAN;
            end
            S_PLAN:
            begin
                if (sp_reg == '0)
                    state_next = S_ORD;
                else if (tn > CW'(1) && texp)
                    state_next = S_MRD;
            end
            S_MRD:
                state_next = S_MWR;
            S_MWR:
            begin
                if (merge_done)
                    state_next = S_CRD;
                else
                    state_next = S_MRD;
            end
            S_CRD:
                state_next = S_CWR;
            S_CWR:
            begin
                if (copy_done)
                    state_next = S_PLAN;
                else
                    state_next = S_CRD;
            end
            S_ORD:
                state_next = S_OSHOW;
            S_OSHOW:
            begin
                if (dst_take)
                    state_next = is_last ? S_LOAD : S_ORD;
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    // counters, bounds and stack pointer
    always_comb
    begin
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        sp_next   = sp_reg;
        li_next   = li_reg;
        le_next   = le_reg;
        ri_next   = ri_reg;
        re_next   = re_reg;
        k_next    = k_reg;
        mlo_next  = mlo_reg;
        idx_next  = idx_reg;
        stk_root  = 1'b0;
        stk_split = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                if (src_take)
                begin
                    cnt_next = cnt_inc;
                    if (cnt_reg == CNT_MAX)
                        ovf_next = 1'b1;
                    if (src_word.last_in)
                    begin
                        stk_root = 1'b1;
                        sp_next  = SPW'(1);
                    end
                end
            end
            S_PLAN:
            begin
                if (sp_reg == '0)
                    idx_next = '0;
                else if (tn <= CW'(1))
                    sp_next = sp_dec;
                else if (!texp)
                begin
                    stk_split = 1'b1;
                    sp_next   = sp_reg + SPW'(2);
                end
                else
                begin
                    sp_next  = sp_dec;
                    li_next  = tlo;
                    le_next  = tlo + th;
                    ri_next  = tlo + th;
                    re_next  = tlo + tn;
                    k_next   = tlo;
                    mlo_next = tlo;
                end
            end
            S_MWR:
            begin
                if (take_left)
                    li_next = li_reg + CW'(1);
                else
                    ri_next = ri_reg + CW'(1);
                k_next = merge_done ? mlo_reg : k_reg + CW'(1);
            end
            S_CWR:
                k_next = k_reg + CW'(1);
            S_OSHOW:
            begin
                if (dst_take)
                begin
                    if (is_last)
                    begin
                        cnt_next = '0;
                        ovf_next = 1'b0;
                    end
                    else
                        idx_next = idx_reg + CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // handshake and memory controls
    always_comb
    begin
        src_stall = 1'b1;
        dst_valid = 1'b0;
        st_we     = 1'b0;
        st_waddr  = cnt_reg[AW-1:0];
        st_wdata  = src_word.value_bits;
        rd_en     = 1'b0;
        ra        = li_reg[AW-1:0];
        rb        = ri_reg[AW-1:0];
        sc_we     = 1'b0;
        sc_re     = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                src_stall = 1'b0;
                st_we     = src_take && (cnt_reg < CNT_MAX);
            end
            S_MRD:
                rd_en = 1'b1;
            S_MWR:
                sc_we = 1'b1;
            S_CRD:
                sc_re = 1'b1;
            S_CWR:
            begin
                st_we    = 1'b1;
                st_waddr = k_reg[AW-1:0];
                st_wdata = sc_reg;
            end
            S_ORD:
            begin
                rd_en = 1'b1;
                ra    = idx_reg[AW-1:0];
                rb    = idx_reg[AW-1:0];
            end
            S_OSHOW:
                dst_valid = 1'b1;
            default:
            begin
            end
        endcase
    end

    assign dst_word.sorted_bits = da_reg;
    assign dst_word.last_out    = is_last;
    assign dst_word.overflow    = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            sp_reg    <= '0;
            li_reg    <= '0;
            le_reg    <= '0;
            ri_reg    <= '0;
            re_reg    <= '0;
            k_reg     <= '0;
            mlo_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            sp_reg    <= sp_next;
            li_reg    <= li_next;
            le_reg    <= le_next;
            ri_reg    <= ri_next;
            re_reg    <= re_next;
            k_reg     <= k_next;
            mlo_reg   <= mlo_next;
            idx_reg   <= idx_next;
        end
    end

    // split stack: mark the parent expanded, push right then left so the
    // left half is sorted first
    always_ff @(posedge clk)
    begin
        if (stk_root)
        begin
            stk_lo[0]  <= '0;
            stk_n[0]   <= cnt_inc;
            stk_exp[0] <= 1'b0;
        end
        if (stk_split)
        begin
            stk_exp[top_idx]   <= 1'b1;
            stk_lo[push0_idx]  <= tlo + th;
            stk_n[push0_idx]   <= tn - th;
            stk_exp[push0_idx] <= 1'b0;
            stk_lo[push1_idx]  <= tlo;
            stk_n[push1_idx]   <= th;
            stk_exp[push1_idx] <= 1'b0;
        end
    end

    // element store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (st_we)
            store_mem[st_waddr] <= st_wdata;
        if (rd_en)
        begin
            da_reg <= store_mem[ra];
            db_reg <= store_mem[rb];
        end
    end

    // merge scratch
    always_ff @(posedge clk)
    begin
        if (sc_we)
            scratch_mem[k_reg[AW-1:0]] <= chosen;
        if (sc_re)
            sc_reg <= scratch_mem[k_reg[AW-1:0]];
    end

endmodule

`default_nettype wire
